// ===== rtl/hsvc_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvc_pkg
// shared widths, constants and pipeline item types of the hsv to rgb converter
// ----------------------------------------------------------------------------
`default_nettype none

package hsvc_pkg;

    // field widths
    localparam int HUE_W  = 15;
    localparam int CHAN_W = 8;

    // gap within a sector, wide enough for the largest sector span
    localparam int GAP_W = 16;

    // hue geometry in degrees
    localparam int SECTOR_DEG = 60;
    localparam int CIRCLE_DEG = 360;

    // full scale of saturation, value and the channels
    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

    // divisor of the middle channel once the power of two part is shifted out
    // (255 * 15, where one sector is 15 << (fraction bits + 2) hue units)
    localparam logic [31:0] MID_DIVISOR    = 32'd3825;
    localparam int          MID_RECIP_SH   = 32;
    localparam logic [31:0] MID_RECIP      = 32'((64'd1 << MID_RECIP_SH) / 64'd3825);

    // divisor of the smallest channel
    localparam logic [31:0] LO_DIVISOR     = 32'd255;
    localparam int          LO_RECIP_SH    = 24;
    localparam logic [31:0] LO_RECIP       = 32'((64'd1 << LO_RECIP_SH) / 64'd255);

    // hue sector, named by the colors at its two ends
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } sector_t;

    // item after hue reduction
    typedef struct packed {
        sector_t             sector;
        logic [GAP_W-1:0]    gap;
        logic [CHAN_W-1:0]   sat;
        logic [CHAN_W-1:0]   val;
    } sector_item_t;

    // item with the three channel levels
    typedef struct packed {
        sector_t             sector;
        logic [CHAN_W-1:0]   hi;
        logic [CHAN_W-1:0]   mid;
        logic [CHAN_W-1:0]   lo;
    } chan_item_t;

endpackage

`default_nettype wire

// ===== rtl/hsvc_hsv_if.sv =====
// ----------------------------------------------------------------------------
// hsvc_hsv_if
// valid / ready channel that carries one hsv color request
// ----------------------------------------------------------------------------
`default_nettype none

interface hsvc_hsv_if import hsvc_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);

endinterface

`default_nettype wire

// ===== rtl/hsvc_rgb_if.sv =====
// ----------------------------------------------------------------------------
// hsvc_rgb_if
// valid / ready channel that carries one rgb color request
// ----------------------------------------------------------------------------
`default_nettype none

interface hsvc_rgb_if import hsvc_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

`default_nettype wire

// ===== rtl/hsvc_sector.sv =====
// ----------------------------------------------------------------------------
// hsvc_sector
// three stage hue front end: wrap to one circle, find sector and gap
// ----------------------------------------------------------------------------
`default_nettype none

module hsvc_sector import hsvc_pkg::*; #(
    parameter int HUE_FRACTION_BITS = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hsv_valid,
    output logic                hsv_ready,
    input  logic [HUE_W-1:0]    hue,
    input  logic [CHAN_W-1:0]   saturation,
    input  logic [CHAN_W-1:0]   brightness,
    output logic                item_valid,
    input  logic                item_ready,
    output sector_item_t        item
);

    localparam logic [31:0] SECTOR_SPAN  = 32'(SECTOR_DEG << HUE_FRACTION_BITS);
    localparam logic [31:0] CIRCLE_SPAN  = 32'(CIRCLE_DEG << HUE_FRACTION_BITS);
    localparam int          RECIP_SH     = 32;
    localparam logic [31:0] CIRCLE_RECIP = 32'((64'd1 << RECIP_SH) / 64'(CIRCLE_SPAN));
    localparam int          HUE_MAX      = (1 << HUE_W) - 1;
    localparam int          WRAP_W       = $clog2(HUE_MAX / int'(CIRCLE_SPAN) + 2);
    localparam int          PROD_W       = HUE_W + 32;

    // stage registers
    logic                s1_valid_reg;
    logic [HUE_W-1:0]    s1_hue_reg;
    logic [CHAN_W-1:0]   s1_sat_reg;
    logic [CHAN_W-1:0]   s1_val_reg;
    logic [WRAP_W-1:0]   s1_wrap_reg;

    logic                s2_valid_reg;
    logic [HUE_W-1:0]    s2_hue_reg;
    logic [CHAN_W-1:0]   s2_sat_reg;
    logic [CHAN_W-1:0]   s2_val_reg;

    logic                s3_valid_reg;
    sector_item_t        s3_item_reg;

    logic                en1;
    logic                en2;
    logic                en3;

    logic [PROD_W-1:0]   wrap_prod;
    logic [WRAP_W-1:0]   s1_wrap_next;
    logic [31:0]         wrap_base;
    logic [31:0]         wrap_rem;
    logic [HUE_W-1:0]    s2_hue_next;
    logic [31:0]         hue_full;
    logic [31:0]         sec_rem;
    logic                rising;
    sector_item_t        s3_item_next;

    // stall chain: a stage loads when it is empty or its successor moves
    assign en3       = !s3_valid_reg || item_ready;
    assign en2       = !s2_valid_reg || en3;
    assign en1       = !s1_valid_reg || en2;
    assign hsv_ready = en1;

    // circle count estimate by reciprocal multiply, low by at most one
    assign wrap_prod    = PROD_W'(hue) * PROD_W'(CIRCLE_RECIP);
    assign s1_wrap_next = WRAP_W'(wrap_prod >> RECIP_SH);

    // remainder with one correction step
    assign wrap_base   = 32'(s1_wrap_reg) * CIRCLE_SPAN;
    assign wrap_rem    = 32'(s1_hue_reg) - wrap_base;
    assign s2_hue_next = (wrap_rem >= CIRCLE_SPAN) ? HUE_W'(wrap_rem - CIRCLE_SPAN)
                                                   : HUE_W'(wrap_rem);

    // sector select and the gap: distance to the far edge in rising sectors, from the near edge in falling ones
    assign hue_full = 32'(s2_hue_reg);

    always_comb
    begin
        s3_item_next.sat = s2_sat_reg;
        s3_item_next.val = s2_val_reg;
        if (hue_full >= 32'd5 * SECTOR_SPAN)
        begin
            s3_item_next.sector = SEC_MR;
            sec_rem             = hue_full - 32'd5 * SECTOR_SPAN;
        end
        else if (hue_full >= 32'd4 * SECTOR_SPAN)
        begin
            s3_item_next.sector = SEC_BM;
            sec_rem             = hue_full - 32'd4 * SECTOR_SPAN;
        end
        else if (hue_full >= 32'd3 * SECTOR_SPAN)
        begin
            s3_item_next.sector = SEC_CB;
            sec_rem             = hue_full - 32'd3 * SECTOR_SPAN;
        end
        else if (hue_full >= 32'd2 * SECTOR_SPAN)
        begin
            s3_item_next.sector = SEC_GC;
            sec_rem             = hue_full - 32'd2 * SECTOR_SPAN;
        end
        else if (hue_full >= SECTOR_SPAN)
        begin
            s3_item_next.sector = SEC_YG;
            sec_rem             = hue_full - SECTOR_SPAN;
        end
        else
        begin
            s3_item_next.sector = SEC_RY;
            sec_rem             = hue_full;
        end
        rising = (s3_item_next.sector == SEC_RY) || (s3_item_next.sector == SEC_GC) ||
                 (s3_item_next.sector == SEC_BM);
        s3_item_next.gap = rising ? GAP_W'(SECTOR_SPAN - sec_rem) : GAP_W'(sec_rem);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= hsv_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_hue_reg  <= hue;
            s1_sat_reg  <= saturation;
            s1_val_reg  <= brightness;
            s1_wrap_reg <= s1_wrap_next;
        end
        if (en2)
        begin
            s2_hue_reg <= s2_hue_next;
            s2_sat_reg <= s1_sat_reg;
            s2_val_reg <= s1_val_reg;
        end
        if (en3)
        begin
            s3_item_reg <= s3_item_next;
        end
    end

    assign item_valid = s3_valid_reg;
    assign item       = s3_item_reg;

endmodule

`default_nettype wire

// ===== rtl/hsvc_channel.sv =====
// ----------------------------------------------------------------------------
// hsvc_channel
// four stage channel math: smallest and middle levels by exact floor division
// ----------------------------------------------------------------------------
`default_nettype none

module hsvc_channel import hsvc_pkg::*; #(
    parameter int HUE_FRACTION_BITS = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  sector_item_t  item,
    output logic          chan_valid,
    input  logic          chan_ready,
    output chan_item_t    chan
);

    // one sector is 15 << ROUND_SH hue units
    localparam int          ROUND_SH  = HUE_FRACTION_BITS + 2;
    localparam logic [32:0] ROUND_ADD = (33'd1 << ROUND_SH) - 33'd1;
    localparam int          PROD_W    = 2 * CHAN_W;
    localparam int          X_W       = PROD_W + GAP_W;
    localparam int          Z_W       = 20;
    localparam int          LO_PW     = PROD_W + 32;
    localparam int          MID_PW    = Z_W + 32;

    logic                s4_valid_reg;
    sector_t             s4_sector_reg;
    logic [GAP_W-1:0]    s4_gap_reg;
    logic [CHAN_W-1:0]   s4_val_reg;
    logic [PROD_W-1:0]   s4_vs_reg;
    logic [PROD_W-1:0]   s4_w_reg;

    logic                s5_valid_reg;
    sector_t             s5_sector_reg;
    logic [CHAN_W-1:0]   s5_val_reg;
    logic [X_W-1:0]      s5_x_reg;
    logic [PROD_W-1:0]   s5_w_reg;
    logic [CHAN_W-1:0]   s5_lo_reg;

    logic                s6_valid_reg;
    sector_t             s6_sector_reg;
    logic [CHAN_W-1:0]   s6_val_reg;
    logic [Z_W-1:0]      s6_z_reg;
    logic [CHAN_W-1:0]   s6_cq_reg;
    logic [CHAN_W-1:0]   s6_lo_reg;

    logic                s7_valid_reg;
    chan_item_t          s7_chan_reg;

    logic                en4;
    logic                en5;
    logic                en6;
    logic                en7;

    logic [PROD_W-1:0]   vs_next;
    logic [PROD_W-1:0]   w_next;
    logic [X_W-1:0]      x_next;
    logic [LO_PW-1:0]    lo_prod;
    logic [32:0]         x_up;
    logic [Z_W-1:0]      z_next;
    logic [MID_PW-1:0]   mid_prod;
    logic [PROD_W-1:0]   lo_rem;
    logic [CHAN_W-1:0]   lo_fix;
    logic [Z_W-1:0]      cq_rem;
    logic [CHAN_W-1:0]   cq_fix;
    chan_item_t          s7_chan_next;

    // stall chain
    assign en7        = !s7_valid_reg || chan_ready;
    assign en6        = !s6_valid_reg || en7;
    assign en5        = !s5_valid_reg || en6;
    assign en4        = !s4_valid_reg || en5;
    assign item_ready = en4;

    // v*s and v*(255-s)
    assign vs_next = PROD_W'(item.val) * PROD_W'(item.sat);
    assign w_next  = PROD_W'(item.val) * PROD_W'(FULL_SCALE - item.sat);

    // chroma share of the gap, and smallest level estimate
    assign x_next  = X_W'(s4_vs_reg) * X_W'(s4_gap_reg);
    assign lo_prod = LO_PW'(s4_w_reg) * LO_PW'(LO_RECIP);

    // ceiling over the power of two, then ceiling over 3825 by reciprocal
    assign x_up     = (33'(s5_x_reg) + ROUND_ADD) >> ROUND_SH;
    assign z_next   = Z_W'(x_up) + Z_W'(MID_DIVISOR - 32'd1);
    assign mid_prod = MID_PW'(z_next) * MID_PW'(MID_RECIP);

    // smallest level correction
    assign lo_rem = s5_w_reg - PROD_W'(s5_lo_reg) * PROD_W'(LO_DIVISOR);
    assign lo_fix = (lo_rem >= PROD_W'(LO_DIVISOR)) ? s5_lo_reg + 8'd1 : s5_lo_reg;

    // middle level correction, then value minus the ceiling
    assign cq_rem = s6_z_reg - Z_W'(s6_cq_reg) * Z_W'(MID_DIVISOR);
    assign cq_fix = (cq_rem >= Z_W'(MID_DIVISOR)) ? s6_cq_reg + 8'd1 : s6_cq_reg;

    always_comb
    begin
        s7_chan_next.sector = s6_sector_reg;
        s7_chan_next.hi     = s6_val_reg;
        s7_chan_next.mid    = s6_val_reg - cq_fix;
        s7_chan_next.lo     = s6_lo_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            if (en4)
            begin
                s4_valid_reg <= item_valid;
            end
            if (en5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (en6)
            begin
                s6_valid_reg <= s5_valid_reg;
            end
            if (en7)
            begin
                s7_valid_reg <= s6_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_sector_reg <= item.sector;
            s4_gap_reg    <= item.gap;
            s4_val_reg    <= item.val;
            s4_vs_reg     <= vs_next;
            s4_w_reg      <= w_next;
        end
        if (en5)
        begin
            s5_sector_reg <= s4_sector_reg;
            s5_val_reg    <= s4_val_reg;
            s5_x_reg      <= x_next;
            s5_w_reg      <= s4_w_reg;
            s5_lo_reg     <= CHAN_W'(lo_prod >> LO_RECIP_SH);
        end
        if (en6)
        begin
            s6_sector_reg <= s5_sector_reg;
            s6_val_reg    <= s5_val_reg;
            s6_z_reg      <= z_next;
            s6_cq_reg     <= CHAN_W'(mid_prod >> MID_RECIP_SH);
            s6_lo_reg     <= lo_fix;
        end
        if (en7)
        begin
            s7_chan_reg <= s7_chan_next;
        end
    end

    assign chan_valid = s7_valid_reg;
    assign chan       = s7_chan_reg;

endmodule

`default_nettype wire

// ===== rtl/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// pipelined six-sector hsv to 8-bit rgb color conversion
// ----------------------------------------------------------------------------
// usage
//   hsv: sink channel, one color request per accepted beat (valid && ready):
//        hue in 2^-HUE_FRACTION_BITS degree, saturation and brightness 0..255
//   rgb: source channel, one red / green / blue request per hsv request,
//        in the same order
//   path: an accepted hsv request passes 3 hue stages, 4 channel stages
//        and 1 output register before rgb valid
//   throughput: one request per cycle while the receiver does not stall; every
//        stage is a register and the widest steps hold two multipliers per stage
//   hue wraps modulo a full circle; results are exact floors, no rounding
//   reset: all valid bits clear at once, the pipeline is empty and ready
//   stall: a stage holds while its successor is full and blocked; empty
//        stages keep filling, so up to 8 requests are held before hsv ready
//        drops, and none is lost or repeated
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter import hsvc_pkg::*; #(
    parameter int HUE_FRACTION_BITS = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    hsvc_hsv_if.sink      hsv,
    hsvc_rgb_if.source    rgb
);

    logic                item_valid;
    logic                item_ready;
    sector_item_t        item;
    logic                chan_valid;
    logic                chan_ready;
    chan_item_t          chan;

    logic                out_valid_reg;
    logic [CHAN_W-1:0]   red_reg;
    logic [CHAN_W-1:0]   green_reg;
    logic [CHAN_W-1:0]   blue_reg;
    logic [CHAN_W-1:0]   red_next;
    logic [CHAN_W-1:0]   green_next;
    logic [CHAN_W-1:0]   blue_next;
    logic                out_en;

    // hue front end
    hsvc_sector #(
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_sector (
        .clk        (clk),
        .rst_n      (rst_n),
        .hsv_valid  (hsv.valid),
        .hsv_ready  (hsv.ready),
        .hue        (hsv.hue),
        .saturation (hsv.saturation),
        .brightness (hsv.brightness),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // channel levels
    hsvc_channel #(
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_channel (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .chan_valid (chan_valid),
        .chan_ready (chan_ready),
        .chan       (chan)
    );

    // route levels to channels by sector
    always_comb
    begin
        case (chan.sector)
            SEC_RY:
            begin
                red_next = chan.hi;  green_next = chan.mid; blue_next = chan.lo;
            end
            SEC_YG:
            begin
                red_next = chan.mid; green_next = chan.hi;  blue_next = chan.lo;
            end
            SEC_GC:
            begin
                red_next = chan.lo;  green_next = chan.hi;  blue_next = chan.mid;
            end
            SEC_CB:
            begin
                red_next = chan.lo;  green_next = chan.mid; blue_next = chan.hi;
            end
            SEC_BM:
            begin
                red_next = chan.mid; green_next = chan.lo;  blue_next = chan.hi;
            end
            default:
            begin
                red_next = chan.hi;  green_next = chan.lo;  blue_next = chan.mid;
            end
        endcase
    end

    // output register
    assign out_en     = !out_valid_reg || rgb.ready;
    assign chan_ready = out_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= chan_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb.valid = out_valid_reg;
    assign rgb.red   = red_reg;
    assign rgb.green = green_reg;
    assign rgb.blue  = blue_reg;

endmodule

`default_nettype wire

// ===== rtl/hsvc_checker.sv =====
// ----------------------------------------------------------------------------
// hsvc_checker
// port level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module hsvc_checker import hsvc_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [CHAN_W-1:0]   red,
    input  logic [CHAN_W-1:0]   green,
    input  logic [CHAN_W-1:0]   blue
);

    localparam int          DEPTH   = 8;
    localparam int          COUNT_W = $clog2(DEPTH + 2);

    logic [COUNT_W-1:0] inflight_reg;
    logic [COUNT_W-1:0] inflight_next;

    // requests accepted and not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_valid && in_ready)
        begin
            inflight_next = inflight_next + 1'b1;
        end
        if (out_valid && out_ready)
        begin
            inflight_next = inflight_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // nothing is shown while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("rgb valid during reset");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({red, green, blue}))
        else $error("stalled rgb request changed");

    // input backpressure only when the whole pipeline is full and blocked
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready && inflight_reg == COUNT_W'(DEPTH))
        else $error("hsv ready low with room in the pipeline");

    // no result without a request behind it, no more than the pipeline holds
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid |-> inflight_reg != '0) && inflight_reg <= COUNT_W'(DEPTH))
        else $error("rgb request count out of step with hsv requests");

endmodule

bind hsv_to_rgb_converter hsvc_checker u_hsvc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (hsv.valid),
    .in_ready  (hsv.ready),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .red       (rgb.red),
    .green     (rgb.green),
    .blue      (rgb.blue)
);

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the hsv to rgb converter: a table of directed colors,
// then random colors, with every rgb request compared field by field against
// the row's own expected rgb or an exact integer six-sector prediction, under
// random idling on both channels, a long receiver hold-off and a full drain pause
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import hsvc_pkg::*;

    // hue geometry at the default fraction width
    localparam int              HUE_FRAC     = 6;
    localparam longint unsigned SECTOR_SPAN  = 64'(SECTOR_DEG) << HUE_FRAC;
    localparam longint unsigned CIRCLE_SPAN  = SECTOR_SPAN * 6;
    localparam longint unsigned SCALE        = 64'd255;

    // run shape
    localparam int RANDOM_ITEMS  = 550;
    localparam int CALM_FIRST    = 100;
    localparam int CALM_LAST     = 199;
    localparam int HOLD_AT       = 250;
    localparam int PAUSE_AT      = 400;
    localparam int HOLD_CYCLES   = 60;
    localparam int DRAIN_CYCLES  = 16;
    localparam int IDLE_PERCENT  = 15;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int ROW_COUNT     = 24;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_color_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] val;
        logic              typed;
        rgb_color_t        color;
    } color_row_t;

    // directed colors; typed rows carry their own expected rgb
    localparam color_row_t COLOR_ROWS [ROW_COUNT] = '{
        '{15'd0,     8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
        '{15'd0,     8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{15'd0,     8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{15'd3840,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
        '{15'd7680,  8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
        '{15'd11520, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
        '{15'd15360, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{15'd19200, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255}},
        '{15'd23039, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{15'd23040, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{15'd32767, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{15'd26880, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
        '{15'd0,     8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
        '{15'd12345, 8'd0,   8'd128, 1'b1, '{8'd128, 8'd128, 8'd128}},
        '{15'd1920,  8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{15'd5760,  8'd128, 8'd200, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{15'd9600,  8'd255, 8'd100, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{15'd13440, 8'd1,   8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{15'd17280, 8'd254, 8'd1,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{15'd21120, 8'd200, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{15'd3839,  8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{15'd3841,  8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{15'd16384, 8'd170, 8'd85,  1'b0, '{8'd0,   8'd0,   8'd0}},
        '{15'd24575, 8'd85,  8'd170, 1'b0, '{8'd0,   8'd0,   8'd0}}
    };

    logic clk = 1'b0;
    logic rst_n;

    hsvc_hsv_if hsv_ch ();
    hsvc_rgb_if rgb_ch ();

    hsv_to_rgb_converter #(
        .HUE_FRACTION_BITS (HUE_FRAC)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hsv   (hsv_ch),
        .rgb   (rgb_ch)
    );

    rgb_color_t color_queue [$];
    int         mismatches  = 0;
    int         cycle_count = 0;
    bit         calm        = 1'b0;
    int         hold_asked  = 0;
    int         hold_seen   = 0;
    int         hold_left   = 0;

    // clock
    always #1 clk = ~clk;

    // exact six-sector conversion over the common denominator 255 * sector
    function automatic rgb_color_t convert_color(logic [HUE_W-1:0] hue,
                                                 logic [CHAN_W-1:0] sat,
                                                 logic [CHAN_W-1:0] val);
        longint unsigned h;
        longint unsigned s;
        longint unsigned v;
        longint unsigned rem;
        longint unsigned gap;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned mid;
        sector_t         sector;
        rgb_color_t      c;
        h      = 64'(hue) % CIRCLE_SPAN;
        s      = 64'(sat);
        v      = 64'(val);
        sector = sector_t'(3'(h / SECTOR_SPAN));
        rem    = h % SECTOR_SPAN;
        // rising sectors count down to the far end, falling ones count up
        gap    = ((h / SECTOR_SPAN) % 2 == 0) ? (SECTOR_SPAN - rem) : rem;
        hi     = v;
        lo     = (v * (SCALE - s)) / SCALE;
        mid    = (SCALE * SECTOR_SPAN * v - v * s * gap) / (SCALE * SECTOR_SPAN);
        case (sector)
            SEC_RY:  c = '{8'(hi),  8'(mid), 8'(lo)};
            SEC_YG:  c = '{8'(mid), 8'(hi),  8'(lo)};
            SEC_GC:  c = '{8'(lo),  8'(hi),  8'(mid)};
            SEC_CB:  c = '{8'(lo),  8'(mid), 8'(hi)};
            SEC_BM:  c = '{8'(mid), 8'(lo),  8'(hi)};
            default: c = '{8'(hi),  8'(lo),  8'(mid)};
        endcase
        return c;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // offer one hsv request, sometimes with a random idle gap ahead of it
    task automatic send_color(logic [HUE_W-1:0] hue, logic [CHAN_W-1:0] sat,
                              logic [CHAN_W-1:0] val, logic typed, rgb_color_t want);
        if (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            hsv_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        hsv_ch.valid      <= 1'b1;
        hsv_ch.hue        <= hue;
        hsv_ch.saturation <= sat;
        hsv_ch.brightness <= val;
        do
            @(posedge clk);
        while (!hsv_ch.ready);
        color_queue.push_back(typed ? want : convert_color(hue, sat, val));
    endtask

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** hsv_to_rgb_converter: FAILED **");
            $finish;
        end
    end

    // receiver: random idling, calm stretch, and a long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
        begin
            rgb_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            rgb_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (hold_seen != hold_asked)
        begin
            rgb_ch.ready <= 1'b0;
            hold_seen    <= hold_asked;
            hold_left    <= HOLD_CYCLES;
        end
        else
        begin
            rgb_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // rgb checker
    always @(posedge clk)
    begin
        rgb_color_t got;
        rgb_color_t want;
        if (rst_n === 1'b1 && rgb_ch.valid && rgb_ch.ready)
        begin
            got = '{rgb_ch.red, rgb_ch.green, rgb_ch.blue};
            if (color_queue.size() == 0)
            begin
                report_mismatch($sformatf("unexpected rgb request %0d/%0d/%0d",
                                          got.red, got.green, got.blue));
            end
            else
            begin
                want = color_queue.pop_front();
                if (got.red !== want.red)
                    report_mismatch($sformatf("red got %0d, expected %0d",
                                              got.red, want.red));
                if (got.green !== want.green)
                    report_mismatch($sformatf("green got %0d, expected %0d",
                                              got.green, want.green));
                if (got.blue !== want.blue)
                    report_mismatch($sformatf("blue got %0d, expected %0d",
                                              got.blue, want.blue));
            end
        end
    end

    // stimulus
    initial
    begin
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] val;
        int                pick;
        rst_n             <= 1'b0;
        hsv_ch.valid      <= 1'b0;
        hsv_ch.hue        <= '0;
        hsv_ch.saturation <= '0;
        hsv_ch.brightness <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < ROW_COUNT; i++)
            send_color(COLOR_ROWS[i].hue, COLOR_ROWS[i].sat, COLOR_ROWS[i].val,
                       COLOR_ROWS[i].typed, COLOR_ROWS[i].color);

        // random colors
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= CALM_FIRST && n <= CALM_LAST);
            if (n == HOLD_AT)
                hold_asked++;
            // pause the sender until the pipeline has drained
            if (n == PAUSE_AT)
            begin
                hsv_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (color_queue.size() != 0);
            end
            pick = $urandom_range(0, 9);
            if (pick == 6)
                hue = HUE_W'((64'($urandom_range(0, 5)) * SECTOR_SPAN + CIRCLE_SPAN
                              + 64'($urandom_range(0, 2)) - 1) % CIRCLE_SPAN);
            else if (pick == 7)
                hue = HUE_W'($urandom_range(0, 32767));
            else
                hue = HUE_W'($urandom_range(0, 23039));
            if ($urandom_range(0, 7) == 0)
                sat = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            else
                sat = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0)
                val = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            else
                val = 8'($urandom_range(0, 255));
            send_color(hue, sat, val, 1'b0, '0);
        end
        hsv_ch.valid <= 1'b0;
        calm = 1'b0;

        // drain, then let the pipeline settle
        while (color_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (color_queue.size() != 0)
            report_mismatch($sformatf("%0d rgb requests never arrived",
                                      color_queue.size()));

        if (mismatches == 0)
            $display("** hsv_to_rgb_converter: PASSED **");
        else
            $display("** hsv_to_rgb_converter: FAILED **");
        $finish;
    end

endmodule
